[rtl/msa_pkg.sv]
// ----------------------------------------------------------------------------
// msa_pkg: shared types and constants for matrix_square_plus_add
// Beat payloads for both channels, the cell control bundle and fixed widths.
// ----------------------------------------------------------------------------
package msa_pkg;

    localparam int DATA_W = 8;   // element width of A and B
    localparam int PROD_W = 16;  // width of one B*B product
    localparam int C_W    = 19;  // result width
    localparam int CFG_W  = 4;   // matrix_size register width

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(8);

    typedef struct packed {
        logic signed [DATA_W-1:0] a_value;
        logic signed [DATA_W-1:0] b_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [C_W-1:0] c_value;
        logic                  last_result;
    } out_beat_t;

    // control shared by every cell of the chain
    typedef struct packed {
        logic op_en;      // accumulate this cycle
        logic op_first;   // first term of a row: seed with A
        logic out_load;   // final term: move the sum into the output stage
        logic out_shift;  // output stage shifts one cell toward cell 0
    } cell_ctl_t;

endpackage

[rtl/msa_ram.sv]
// ----------------------------------------------------------------------------
// msa_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module msa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                   wdata,
    input  logic                               re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/msa_cell.sv]
// ----------------------------------------------------------------------------
// msa_cell: one column cell of the multiply-accumulate chain
// Holds one column of A and B, accumulates one element of a result row and
// passes finished results toward cell 0 through its output stage.
// ----------------------------------------------------------------------------
module msa_cell #(
    parameter int MAX_SIZE = 8
) (
    input  logic                                   clk,
    input  msa_pkg::cell_ctl_t                     ctl,
    input  logic                                   wr_en,
    input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] wr_idx,
    input  logic signed [msa_pkg::DATA_W-1:0]      wr_a,
    input  logic signed [msa_pkg::DATA_W-1:0]      wr_b,
    input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] op_k,
    input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] op_row,
    input  logic signed [msa_pkg::DATA_W-1:0]      b_bcast,
    input  logic signed [msa_pkg::C_W-1:0]         shift_in,
    output logic signed [msa_pkg::C_W-1:0]         out_value
);

    localparam int XW = msa_pkg::C_W - msa_pkg::DATA_W;
    localparam int PW = msa_pkg::C_W - msa_pkg::PROD_W;

    logic signed [msa_pkg::DATA_W-1:0] a_col_reg [MAX_SIZE];
    logic signed [msa_pkg::DATA_W-1:0] b_col_reg [MAX_SIZE];
    logic signed [msa_pkg::C_W-1:0]    acc_reg;
    logic signed [msa_pkg::C_W-1:0]    acc_next;
    logic signed [msa_pkg::C_W-1:0]    out_reg;
    logic signed [msa_pkg::C_W-1:0]    out_next;
    logic signed [msa_pkg::PROD_W-1:0] prod;
    logic signed [msa_pkg::DATA_W-1:0] a_sel;
    logic signed [msa_pkg::C_W-1:0]    base;

    assign prod  = b_bcast * b_col_reg[op_k];
    assign a_sel = a_col_reg[op_row];

    always_comb
    begin
        if (ctl.op_first)
        begin
            base = {{XW{a_sel[msa_pkg::DATA_W-1]}}, a_sel};
        end
        else
        begin
            base = acc_reg;
        end
        // low bits only: wraps exactly like the 19-bit result
        acc_next = base + {{PW{prod[msa_pkg::PROD_W-1]}}, prod};

        if (ctl.out_load)
        begin
            out_next = acc_next;
        end
        else if (ctl.out_shift)
        begin
            out_next = shift_in;
        end
        else
        begin
            out_next = out_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            a_col_reg[wr_idx] <= wr_a;
            b_col_reg[wr_idx] <= wr_b;
        end
        if (ctl.op_en)
        begin
            acc_reg <= acc_next;
        end
        out_reg <= out_next;
    end

    assign out_value = out_reg;

endmodule

[rtl/matrix_square_plus_add.sv]
// ----------------------------------------------------------------------------
// matrix_square_plus_add: C = A + B*B for square integer matrices
// Loads A and B in row-major order, then computes and streams out C.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ------------------------------
//  in        in         in_valid / in_ready  a_value, b_value (8b signed)
//  out       out        out_valid/out_ready  c_value (19b signed), last
//  cfg       in         cfg_we               cfg_data = matrix_size (4b)
//
//  Load: one input beat per cycle, n*n beats per matrix pair (n = size used).
//  Compute: n B reads per result row and n*n per matrix; the single read
//  port of the B memory feeds one B element per cycle when not stalled.
//  Rows of C drain through the cell output stages while the next row is
//  computed; a stalled output freezes the compute pipeline. Input is not
//  taken during compute. Reset sets matrix_size to 8 and clears load state.
//
// ----------------------------------------------------------------------------
module matrix_square_plus_add #(
    parameter int MAX_SIZE = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  msa_pkg::in_beat_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output msa_pkg::out_beat_t             out_data,
    input  logic                           cfg_we,
    input  logic [msa_pkg::CFG_W-1:0]      cfg_data
);

    // index into a row or column, size value, memory address, element count
    localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NW    = $clog2(MAX_SIZE + 1);
    localparam int ELEMS = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (ELEMS > 1) ? $clog2(ELEMS) : 1;
    localparam int CW    = $clog2(ELEMS + 1);

    typedef enum logic [1:0] {
        ST_LOAD,   // taking input beats
        ST_RUN,    // issuing B reads, one per cycle unless stalled
        ST_FLUSH   // last operation still in the pipeline
    } state_t;

    state_t                   state_reg;
    logic [msa_pkg::CFG_W-1:0] size_reg;

    // size actually used, clamped to 1..MAX_SIZE
    logic [NW-1:0] n_use;
    logic [NW-1:0] n_last;
    logic [CW-1:0] total;

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_use = NW'(1);
        end
        else if (int'(size_reg) > MAX_SIZE)
        begin
            n_use = NW'(MAX_SIZE);
        end
        else
        begin
            n_use = NW'(size_reg);
        end
        n_last = n_use - NW'(1);
        total  = CW'(n_use) * CW'(n_use);
    end

    // load side counters
    logic [CW-1:0] load_cnt_reg;
    logic [IW-1:0] load_row_reg;
    logic [IW-1:0] load_col_reg;
    logic          in_accept;
    logic          load_done;

    // issue side counters
    logic [CW-1:0] iss_addr_reg;
    logic [IW-1:0] iss_k_reg;
    logic [IW-1:0] iss_row_reg;
    logic          issue;
    logic          iss_done;

    // operation stage, aligned with the RAM read data
    logic          op_valid_reg;
    logic          op_first_reg;
    logic          op_last_reg;
    logic          op_lastrow_reg;
    logic [IW-1:0] op_k_reg;
    logic [IW-1:0] op_row_reg;

    // output stage bookkeeping
    logic [NW-1:0] out_cnt_reg;
    logic          out_lastrow_reg;
    logic          out_accept;
    logic          out_free;
    logic          stall;
    logic          advance;

    msa_pkg::cell_ctl_t            ctl;
    logic [msa_pkg::DATA_W-1:0]    b_rdata;
    logic signed [msa_pkg::C_W-1:0] cell_out [MAX_SIZE];

    assign in_ready   = (state_reg == ST_LOAD);
    assign in_accept  = in_valid && in_ready;
    assign load_done  = (load_cnt_reg + CW'(1)) == total;

    assign out_valid  = (out_cnt_reg != '0);
    assign out_accept = out_valid && out_ready;
    // output stages may take a new row when empty or emptying now
    assign out_free   = (out_cnt_reg == '0) || ((out_cnt_reg == NW'(1)) && out_ready);
    assign stall      = op_valid_reg && op_last_reg && !out_free;
    assign advance    = !stall;
    assign issue      = (state_reg == ST_RUN) && advance;
    assign iss_done   = (iss_addr_reg + CW'(1)) == total;

    assign ctl.op_en     = op_valid_reg && advance;
    assign ctl.op_first  = op_first_reg;
    assign ctl.out_load  = op_valid_reg && advance && op_last_reg;
    assign ctl.out_shift = out_accept;

    assign out_data.c_value     = cell_out[0];
    assign out_data.last_result = out_lastrow_reg && (out_cnt_reg == NW'(1));

    // sequencer and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            size_reg     <= msa_pkg::SIZE_RESET;
            load_cnt_reg <= '0;
            load_row_reg <= '0;
            load_col_reg <= '0;
            iss_addr_reg <= '0;
            iss_k_reg    <= '0;
            iss_row_reg  <= '0;
            op_valid_reg <= 1'b0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                // new size drops any partial load
                size_reg     <= cfg_data;
                load_cnt_reg <= '0;
                load_row_reg <= '0;
                load_col_reg <= '0;
            end
            else if (in_accept)
            begin
                if (load_done)
                begin
                    load_cnt_reg <= '0;
                    load_row_reg <= '0;
                    load_col_reg <= '0;
                end
                else
                begin
                    load_cnt_reg <= load_cnt_reg + CW'(1);
                    if (NW'(load_col_reg) == n_last)
                    begin
                        load_col_reg <= '0;
                        load_row_reg <= load_row_reg + IW'(1);
                    end
                    else
                    begin
                        load_col_reg <= load_col_reg + IW'(1);
                    end
                end
            end

            case (state_reg)
                ST_LOAD:
                begin
                    if (in_accept && load_done && !cfg_we)
                    begin
                        state_reg    <= ST_RUN;
                        iss_addr_reg <= '0;
                        iss_k_reg    <= '0;
                        iss_row_reg  <= '0;
                    end
                end
                ST_RUN:
                begin
                    if (issue)
                    begin
                        iss_addr_reg <= iss_addr_reg + CW'(1);
                        if (NW'(iss_k_reg) == n_last)
                        begin
                            iss_k_reg   <= '0;
                            iss_row_reg <= iss_row_reg + IW'(1);
                        end
                        else
                        begin
                            iss_k_reg <= iss_k_reg + IW'(1);
                        end
                        if (iss_done)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    // the final operation leaves the pipeline this cycle
                    if (advance)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase

            if (advance)
            begin
                op_valid_reg <= issue;
            end

            if (ctl.out_load)
            begin
                out_cnt_reg <= n_use;
            end
            else if (out_accept)
            begin
                out_cnt_reg <= out_cnt_reg - NW'(1);
            end
        end
    end

    // operation and output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            op_first_reg   <= (iss_k_reg == '0);
            op_last_reg    <= (NW'(iss_k_reg) == n_last);
            op_lastrow_reg <= (NW'(iss_row_reg) == n_last);
            op_k_reg       <= iss_k_reg;
            op_row_reg     <= iss_row_reg;
        end
        if (ctl.out_load)
        begin
            out_lastrow_reg <= op_lastrow_reg;
        end
    end

    // B in row-major order: a row of B streams out as one row of reads
    msa_ram #(
        .WIDTH (msa_pkg::DATA_W),
        .DEPTH (ELEMS)
    ) u_b_ram (
        .clk   (clk),
        .we    (in_accept),
        .waddr (load_cnt_reg[AW-1:0]),
        .wdata (in_data.b_value),
        .re    (issue),
        .raddr (iss_addr_reg[AW-1:0]),
        .rdata (b_rdata)
    );

    // cell j holds column j of A and B and works out C[row][j];
    // finished rows shift toward cell 0, which drives the output beat
    for (genvar j = 0; j < MAX_SIZE; j++)
    begin : g_cell
        logic                           wr_sel;
        logic signed [msa_pkg::C_W-1:0] next_out;

        assign wr_sel = in_accept && (load_col_reg == IW'(j));

        if (j == MAX_SIZE - 1)
        begin : g_end
            assign next_out = '0;
        end
        else
        begin : g_mid
            assign next_out = cell_out[j + 1];
        end

        msa_cell #(
            .MAX_SIZE (MAX_SIZE)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .wr_en     (wr_sel),
            .wr_idx    (load_row_reg),
            .wr_a      (in_data.a_value),
            .wr_b      (in_data.b_value),
            .op_k      (op_k_reg),
            .op_row    (op_row_reg),
            .b_bcast   (b_rdata),
            .shift_in  (next_out),
            .out_value (cell_out[j])
        );
    end

endmodule

[verif/matrix_square_plus_add_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_square_plus_add_tb: self-checking bench for C = A + B*B
// Streams A/B element pairs under random gaps and output stalls, works out
// every result matrix inside the bench and checks each output beat in order.
// ----------------------------------------------------------------------------
module matrix_square_plus_add_tb;

    localparam int MAX_SIZE      = 8;
    localparam int MAX_ELEMS     = MAX_SIZE * MAX_SIZE;
    localparam int IDLE_PCT      = 32;     // chance of an idle cycle on either side
    localparam int SETTLE_CYCLES = 16;     // quiet cycles before a size write

    localparam logic signed [msa_pkg::DATA_W-1:0] DATA_MAX = 8'sh7f;
    localparam logic signed [msa_pkg::DATA_W-1:0] DATA_MIN = 8'sh80;

    // content patterns for a loaded matrix pair
    typedef enum int {
        FILL_RANDOM,    // any values
        FILL_EXTREME,   // only the two end values
        FILL_CHECKER,   // B checkerboard, drives odd-parity results to the low end
        FILL_PEAK,      // B all minimum, A all maximum: top of the result range
        FILL_SMALL      // values near zero
    } fill_kind_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      in_valid     = 1'b0;
    logic                      in_ready;
    msa_pkg::in_beat_t         in_data      = '0;
    logic                      out_valid;
    logic                      out_ready    = 1'b0;
    msa_pkg::out_beat_t        out_data;
    logic                      cfg_we       = 1'b0;
    logic [msa_pkg::CFG_W-1:0] cfg_data     = '0;

    // bench controls
    logic                gap_enable   = 1'b1;   // sender inserts idle cycles
    logic                stall_enable = 1'b1;   // receiver drops ready at random
    logic                valid_on     = 1'b0;   // mirror of in_valid as last driven

    // bench copy of the block state
    logic [msa_pkg::CFG_W-1:0] size_model = msa_pkg::SIZE_RESET;
    int                        fill_count = 0;
    int                        a_mem [MAX_ELEMS];
    int                        b_mem [MAX_ELEMS];
    msa_pkg::out_beat_t        c_expected [$];

    // run statistics
    int                  mismatch_count = 0;
    int                  result_count   = 0;
    int                  matrix_count   = 0;
    int                  size_writes    = 0;

    matrix_square_plus_add #(
        .MAX_SIZE (MAX_SIZE)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // hard stop far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $display("  timeout at %0t with %0d results still outstanding",
                 $time, c_expected.size());
        $finish;
    end

    // receiver: ready toggles at random unless the test asks for full rate
    always @(posedge clk)
    begin
        out_ready <= stall_enable ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    // matrix size the block actually uses: zero acts as one, big values clamp
    function automatic int effective_size(input logic [msa_pkg::CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_SIZE)
            return MAX_SIZE;
        return int'(v);
    endfunction

    // Store one element pair; on the last element of the pair compute every
    // C[r][c] = A[r][c] + sum_k B[r][k]*B[k][c], low C_W bits, row-major.
    task automatic predict_square_sum(input msa_pkg::in_beat_t beat);
        int                 n;
        int                 acc;
        msa_pkg::out_beat_t res;
        n = effective_size(size_model);
        if (fill_count >= n * n)
            fill_count = 0;
        a_mem[fill_count] = $signed(beat.a_value);
        b_mem[fill_count] = $signed(beat.b_value);
        fill_count++;
        if (fill_count == n * n)
        begin
            for (int r = 0; r < n; r++)
            begin
                for (int c = 0; c < n; c++)
                begin
                    acc = a_mem[r * n + c];
                    for (int k = 0; k < n; k++)
                        acc += b_mem[r * n + k] * b_mem[k * n + c];
                    res.c_value     = acc[msa_pkg::C_W-1:0];
                    res.last_result = (r * n + c == n * n - 1);
                    c_expected.push_back(res);
                end
            end
            fill_count = 0;
            matrix_count++;
        end
    endtask

    // One monitor for all channels so queue pushes and pops never race.
    // Values read here are the ones present just before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (c_expected.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, expected none, got c=%0d last=%0b",
                             $time, $signed(out_data.c_value), out_data.last_result);
                end
                else
                begin
                    msa_pkg::out_beat_t want;
                    want = c_expected.pop_front();
                    if (out_data.c_value !== want.c_value)
                    begin
                        mismatch_count++;
                        $display("%0t: c_value mismatch, expected %0d, got %0d",
                                 $time, $signed(want.c_value), $signed(out_data.c_value));
                    end
                    if (out_data.last_result !== want.last_result)
                    begin
                        mismatch_count++;
                        $display("%0t: last_result mismatch, expected %0b, got %0b",
                                 $time, want.last_result, out_data.last_result);
                    end
                end
            end
            // a size write restarts loading
            if (cfg_we)
            begin
                size_model = cfg_data;
                fill_count = 0;
            end
            if (in_valid && in_ready)
                predict_square_sum(in_data);
        end
    end

    // drop valid, at most once per time step
    task automatic hold_input();
        if (valid_on)
        begin
            in_valid <= 1'b0;
            valid_on = 1'b0;
        end
    endtask

    // Send one beat; returns in the step of the edge that accepted it, so
    // the next call can keep valid high without a glitch.
    task automatic send_beat(input msa_pkg::in_beat_t beat);
        while (gap_enable && $urandom_range(99) < IDLE_PCT)
        begin
            hold_input();
            @(posedge clk);
        end
        in_valid <= 1'b1;
        valid_on = 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // sender hold-off until every predicted result has been taken; the first
    // edge lets the monitor book a matrix finished by the last accepted beat
    task automatic wait_for_results();
        hold_input();
        @(posedge clk);
        while (c_expected.size() != 0)
            @(posedge clk);
    endtask

    // size register is only touched with the block idle
    task automatic write_size(input logic [msa_pkg::CFG_W-1:0] v);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        size_writes++;
    endtask

    function automatic msa_pkg::in_beat_t make_beat(input fill_kind_t kind, input int idx,
                                                    input int n);
        msa_pkg::in_beat_t beat;
        logic              odd;
        odd = (((idx / n) + (idx % n)) % 2) != 0;
        case (kind)
            FILL_EXTREME:
            begin
                beat.a_value = $urandom_range(1) ? DATA_MAX : DATA_MIN;
                beat.b_value = $urandom_range(1) ? DATA_MAX : DATA_MIN;
            end
            FILL_CHECKER:
            begin
                beat.a_value = odd ? DATA_MIN : DATA_MAX;
                beat.b_value = odd ? DATA_MAX : DATA_MIN;
            end
            FILL_PEAK:
            begin
                beat.a_value = DATA_MAX;
                beat.b_value = DATA_MIN;
            end
            FILL_SMALL:
            begin
                beat.a_value = msa_pkg::DATA_W'(int'($urandom_range(6)) - 3);
                beat.b_value = msa_pkg::DATA_W'(int'($urandom_range(6)) - 3);
            end
            default:
                beat = msa_pkg::in_beat_t'(16'($urandom));
        endcase
        return beat;
    endfunction

    function automatic fill_kind_t pick_fill();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return FILL_RANDOM;
        if (roll < 70)
            return FILL_EXTREME;
        if (roll < 80)
            return FILL_CHECKER;
        if (roll < 90)
            return FILL_PEAK;
        return FILL_SMALL;
    endfunction

    // mostly small sizes; zero and oversize values show up now and then
    function automatic logic [msa_pkg::CFG_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return '0;
        if (roll < 66)
            return msa_pkg::CFG_W'($urandom_range(3, 1));
        if (roll < 86)
            return msa_pkg::CFG_W'($urandom_range(5, 4));
        if (roll < 95)
            return msa_pkg::CFG_W'($urandom_range(8, 6));
        return msa_pkg::CFG_W'($urandom_range(15, 9));
    endfunction

    // count beats of pattern kind laid out on an n x n grid
    task automatic send_matrix(input int n, input fill_kind_t kind, input int count);
        for (int i = 0; i < count; i++)
            send_beat(make_beat(kind, i % (n * n), n));
    endtask

    // Random matrices with a size write between groups; some groups end in a
    // partial load that the next size write must throw away.
    task automatic random_stream(input int budget, input logic [msa_pkg::CFG_W-1:0] first_size);
        int                        sent;
        int                        n;
        int                        reps;
        int                        cut;
        logic [msa_pkg::CFG_W-1:0] sz;
        sent = 0;
        sz   = first_size;
        while (sent < budget)
        begin
            write_size(sz);
            n    = effective_size(sz);
            reps = (n > 5) ? 1 : $urandom_range(3, 1);
            repeat (reps)
            begin
                send_matrix(n, pick_fill(), n * n);
                sent += n * n;
            end
            if (n > 1 && $urandom_range(99) < 20)
            begin
                cut = $urandom_range(n * n - 1, 1);
                send_matrix(n, FILL_RANDOM, cut);
                sent += cut;
            end
            sz = pick_size();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // no size write yet: the reset size (full 8x8) must be in force; the
    // checkerboard reaches the bottom of the result range
    task automatic test_reset_size();
        send_matrix(MAX_SIZE, FILL_CHECKER, MAX_ELEMS);
    endtask

    // 1x1 with every sign combination of the end values, then size zero,
    // which must behave as 1x1
    task automatic test_unit_size();
        msa_pkg::in_beat_t beat;
        write_size(msa_pkg::CFG_W'(1));
        beat = '{a_value: DATA_MIN, b_value: DATA_MIN}; send_beat(beat);
        beat = '{a_value: DATA_MAX, b_value: DATA_MAX}; send_beat(beat);
        beat = '{a_value: DATA_MIN, b_value: DATA_MAX}; send_beat(beat);
        beat = '{a_value: DATA_MAX, b_value: DATA_MIN}; send_beat(beat);
        write_size('0);
        beat = '{a_value: '0, b_value: '0};             send_beat(beat);
        beat = '{a_value: DATA_MAX, b_value: DATA_MIN}; send_beat(beat);
    endtask

    // 2x2 with end values and -1
    task automatic test_size_two();
        msa_pkg::in_beat_t beat;
        write_size(msa_pkg::CFG_W'(2));
        beat = '{a_value: DATA_MIN, b_value: DATA_MIN}; send_beat(beat);
        beat = '{a_value: DATA_MAX, b_value: DATA_MAX}; send_beat(beat);
        beat = '{a_value: '0,       b_value: DATA_MIN}; send_beat(beat);
        beat = '{a_value: '1,       b_value: DATA_MAX}; send_beat(beat);
    endtask

    // size write in the middle of a load drops the partial matrices
    task automatic test_reload_on_write();
        write_size(msa_pkg::CFG_W'(3));
        send_matrix(3, FILL_RANDOM, 5);
        write_size(msa_pkg::CFG_W'(2));
        send_matrix(2, FILL_RANDOM, 4);
    endtask

    // bulk random traffic with gaps and stalls; starts at the largest code
    task automatic test_random_mix();
        random_stream(180, msa_pkg::CFG_W'(15));
    endtask

    // long stretch at full rate on both sides
    task automatic test_back_to_back();
        gap_enable   = 1'b0;
        stall_enable = 1'b0;
        random_stream(100, msa_pkg::CFG_W'(MAX_SIZE));
        gap_enable   = 1'b1;
        stall_enable = 1'b1;
    endtask

    // sender holds off until the output side has caught up, including in
    // the middle of a load, where the loaded elements must be kept
    task automatic test_drain_pause();
        int                        sent;
        int                        n;
        logic [msa_pkg::CFG_W-1:0] sz;
        write_size(msa_pkg::CFG_W'(3));
        send_matrix(3, FILL_RANDOM, 9);
        send_matrix(3, FILL_RANDOM, 4);
        wait_for_results();
        send_matrix(3, FILL_RANDOM, 5);
        sent = 18;
        while (sent < 100)
        begin
            sz = pick_size();
            write_size(sz);
            n = effective_size(sz);
            send_matrix(n, pick_fill(), n * n);
            wait_for_results();
            sent += n * n;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_size();
        test_unit_size();
        test_size_two();
        test_reload_on_write();
        test_random_mix();
        test_back_to_back();
        test_drain_pause();

        // let the last matrix drain, then watch for stray beats
        wait_for_results();
        repeat (2 * MAX_ELEMS + SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d matrix pairs and %0d result beats over %0d size writes,",
                 matrix_count, result_count, size_writes);
        $display("sizes 0 to 15, mid-load size changes, full rate and drain pauses.");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
